// ===== rtl/telemetry_command_frame_parser_top_defines.svh =====
// Assertion macros shared by the telemetry command frame parser RTL.
`ifndef TELEMETRY_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define TELEMETRY_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define TCFP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcfp assertion failed");

`define TCFP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcfp implication failed");

`define TCFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcfp next-cycle check failed");

`else

`define TCFP_ASSERT(name, clk, rst_n, prop)
`define TCFP_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TCFP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tcfp_pkg.sv =====
// Types and constants of the telemetry command frame parser.
package tcfp_pkg;

    localparam int MAX_PAYLOAD  = 49;
    localparam int STORE_DEPTH  = 18;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    localparam int GAIN_COUNT   = 9;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
    localparam logic [7:0] FUNC_QUERY  = 8'h02;
    localparam logic [7:0] CMD_PID     = 8'h01;
    localparam logic [7:0] CMD_VERSION = 8'hA0;
    localparam logic [7:0] FUNC_GAINS  = 8'h10;
    localparam logic [7:0] FUNC_ACK_A  = 8'h11;
    localparam logic [7:0] FUNC_ACK_B  = 8'h12;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_FUNC,
        PH_LEN,
        PH_PAYLOAD,
        PH_CSUM
    } phase_t;

    typedef enum logic [1:0] {
        EV_PID,
        EV_VERSION,
        EV_GAINS,
        EV_ACK
    } event_t;

    typedef struct packed {
        event_t                          event_res;
        logic [7:0]                      func;
        logic [7:0]                      sum;
        logic [GAIN_COUNT-1:0][15:0]     gains;
    } item_t;

endpackage

// ===== rtl/tcfp_front.sv =====
// Frame hunter: header, function, length, payload and checksum parsing.
module tcfp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    output logic             push,
    output tcfp_pkg::item_t  push_item
);

    tcfp_pkg::phase_t                 phase_reg, phase_next;
    logic [5:0]                       bytes_left_reg, bytes_left_next;
    logic [5:0]                       index_reg, index_next;
    logic [7:0]                       sum_reg, sum_next;
    logic [7:0]                       func_reg, func_next;
    logic [7:0] store_reg  [tcfp_pkg::STORE_DEPTH];
    logic [7:0] store_next [tcfp_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= tcfp_pkg::PH_HDR1;
            bytes_left_reg <= '0;
            index_reg      <= '0;
            sum_reg        <= '0;
            func_reg       <= '0;
            for (int i = 0; i < tcfp_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            index_reg      <= index_next;
            sum_reg        <= sum_next;
            func_reg       <= func_next;
            for (int i = 0; i < tcfp_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_comb begin
        // Gain words are built from the stored payload; the back end zeroes them
        // for every event other than a gain load.
        for (int k = 0; k < tcfp_pkg::GAIN_COUNT; k++) begin
            push_item.gains[k] = {store_reg[2*k], store_reg[2*k+1]};
        end
        push_item.func      = func_reg;
        push_item.sum       = rx_byte;
        phase_next          = phase_reg;
        bytes_left_next     = bytes_left_reg;
        index_next          = index_reg;
        sum_next            = sum_reg;
        func_next           = func_reg;
        store_next          = store_reg;
        push                = 1'b0;
        push_item.event_res = tcfp_pkg::EV_ACK;

        if (byte_valid) begin
            unique case (phase_reg)
                tcfp_pkg::PH_HDR1: begin
                    if (rx_byte == tcfp_pkg::HDR_FIRST) begin
                        phase_next = tcfp_pkg::PH_HDR2;
                        sum_next   = rx_byte;
                    end
                end
                tcfp_pkg::PH_HDR2: begin
                    if (rx_byte == tcfp_pkg::HDR_SECOND) begin
                        phase_next = tcfp_pkg::PH_FUNC;
                        sum_next   = sum_reg + rx_byte;
                    end else begin
                        phase_next = tcfp_pkg::PH_HDR1;
                    end
                end
                tcfp_pkg::PH_FUNC: begin
                    if (rx_byte < tcfp_pkg::FUNC_LIMIT) begin
                        phase_next = tcfp_pkg::PH_LEN;
                        func_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                    end else begin
                        phase_next = tcfp_pkg::PH_HDR1;
                    end
                end
                tcfp_pkg::PH_LEN: begin
                    if (rx_byte <= 8'(tcfp_pkg::MAX_PAYLOAD)) begin
                        bytes_left_next = rx_byte[5:0];
                        index_next      = '0;
                        sum_next        = sum_reg + rx_byte;
                        // An empty frame goes straight to its checksum byte.
                        phase_next      = (rx_byte == 8'd0) ? tcfp_pkg::PH_CSUM
                                                            : tcfp_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = tcfp_pkg::PH_HDR1;
                    end
                end
                tcfp_pkg::PH_PAYLOAD: begin
                    if (bytes_left_reg != 6'd0) begin
                        if (index_reg < 6'(tcfp_pkg::STORE_DEPTH)) begin
                            store_next[index_reg[tcfp_pkg::STORE_IDX_W-1:0]] = rx_byte;
                        end
                        index_next      = index_reg + 6'd1;
                        bytes_left_next = bytes_left_reg - 6'd1;
                        sum_next        = sum_reg + rx_byte;
                        if (bytes_left_reg == 6'd1) begin
                            phase_next = tcfp_pkg::PH_CSUM;
                        end
                    end else begin
                        phase_next = tcfp_pkg::PH_HDR1;
                    end
                end
                tcfp_pkg::PH_CSUM: begin
                    phase_next = tcfp_pkg::PH_HDR1;
                    if (rx_byte == sum_reg) begin
                        unique case (func_reg)
                            tcfp_pkg::FUNC_QUERY: begin
                                if (store_reg[0] == tcfp_pkg::CMD_PID) begin
                                    push                = 1'b1;
                                    push_item.event_res = tcfp_pkg::EV_PID;
                                end else if (store_reg[0] == tcfp_pkg::CMD_VERSION) begin
                                    push                = 1'b1;
                                    push_item.event_res = tcfp_pkg::EV_VERSION;
                                end
                            end
                            tcfp_pkg::FUNC_GAINS: begin
                                push                = 1'b1;
                                push_item.event_res = tcfp_pkg::EV_GAINS;
                            end
                            tcfp_pkg::FUNC_ACK_A,
                            tcfp_pkg::FUNC_ACK_B: begin
                                push                = 1'b1;
                                push_item.event_res = tcfp_pkg::EV_ACK;
                            end
                            default: begin
                                push = 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = tcfp_pkg::PH_HDR1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/tcfp_queue.sv =====
// Short queue of decoded frames between the parser and the output stage.
`include "telemetry_command_frame_parser_top_defines.svh"

module tcfp_queue #(
    parameter int DEPTH = tcfp_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tcfp_pkg::item_t  push_item,
    input  logic             pop,
    output tcfp_pkg::item_t  head_item,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcfp_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head_item = mem[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    `TCFP_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `TCFP_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full || pop)
    `TCFP_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !empty)
    `TCFP_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== rtl/tcfp_back.sv =====
// Output stage: takes decoded frames from the queue and holds the result transfer.
module tcfp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  tcfp_pkg::item_t  head_item,
    output logic             pop,
    input  logic             m_ready,
    output logic             m_valid,
    output tcfp_pkg::item_t  result
);

    logic            valid_reg, valid_next;
    tcfp_pkg::item_t result_reg;

    assign pop = !q_empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Gains are only meaningful for a gain load; other events report zero.
    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg.event_res <= head_item.event_res;
            result_reg.func      <= head_item.func;
            result_reg.sum       <= head_item.sum;
            result_reg.gains     <= (head_item.event_res == tcfp_pkg::EV_GAINS)
                                    ? head_item.gains : '0;
        end
    end

    assign m_valid = valid_reg;
    assign result  = result_reg;

endmodule

// ===== rtl/telemetry_command_frame_parser_top.sv =====
// Top level of the telemetry command frame parser.
//
// The input channel takes one received byte per transfer on s_rx_byte. The
// parser hunts for the header 0xAA 0xAF, then a function byte, a length byte,
// that many payload bytes and an additive 8-bit checksum. A frame whose
// checksum matches and whose function (and query command) is known yields
// one result transfer on the m_ channel: the event code, the echoed function
// byte and checksum, and for a gain load the nine signed gains in thousandths
// (zero otherwise). A bad checksum or an unknown function gives nothing.
//
// Throughput is one byte per clock while s_ready is high. The result of a
// frame enters the queue at the edge that transfers its checksum byte and
// shows on m_valid once the output register is free to load it. A short queue
// decouples the parser from the output register, so bytes keep flowing while
// a result waits. When the receiver holds m_ready low, results collect in the
// queue; once it is full, s_ready drops until the output register drains.
// Reset clears the parser to hunting the first header byte, clears the stored
// payload, and empties the queue and the output register.
module telemetry_command_frame_parser_top #(
    parameter int QUEUE_DEPTH = tcfp_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_res,
    output logic [7:0]         m_frame_function,
    output logic [7:0]         m_frame_sum,
    output logic signed [15:0] m_roll_p_gain,
    output logic signed [15:0] m_roll_i_gain,
    output logic signed [15:0] m_roll_d_gain,
    output logic signed [15:0] m_pitch_p_gain,
    output logic signed [15:0] m_pitch_i_gain,
    output logic signed [15:0] m_pitch_d_gain,
    output logic signed [15:0] m_yaw_p_gain,
    output logic signed [15:0] m_yaw_i_gain,
    output logic signed [15:0] m_yaw_d_gain
);

    logic            byte_valid;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    tcfp_pkg::item_t push_item;
    tcfp_pkg::item_t head_item;
    tcfp_pkg::item_t result;

    // A byte is only taken while the queue can absorb a possible result.
    assign s_ready    = !q_full;
    assign byte_valid = s_valid && s_ready;

    tcfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .rx_byte    (s_rx_byte),
        .push       (push),
        .push_item  (push_item)
    );

    tcfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .head_item (head_item),
        .pop       (pop),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .result    (result)
    );

    // Gain words follow payload order: roll, pitch, yaw; P, I, D within each.
    assign m_event_res      = result.event_res;
    assign m_frame_function = result.func;
    assign m_frame_sum      = result.sum;
    assign m_roll_p_gain    = result.gains[0];
    assign m_roll_i_gain    = result.gains[1];
    assign m_roll_d_gain    = result.gains[2];
    assign m_pitch_p_gain   = result.gains[3];
    assign m_pitch_i_gain   = result.gains[4];
    assign m_pitch_d_gain   = result.gains[5];
    assign m_yaw_p_gain     = result.gains[6];
    assign m_yaw_i_gain     = result.gains[7];
    assign m_yaw_d_gain     = result.gains[8];

endmodule
